// File: rtl/core/mrad_pkg.sv
// Package for the MMIO region address decoder: sizes, codes, and the
// token and result structs passed between the sequencer, cells and output stage.
// Depends on nothing.
`default_nettype none

package mrad_pkg;

  localparam int REGION_COUNT     = 16;
  localparam int MAX_ACCESS_BYTES = 8;
  localparam int STEP_RESULTS     = 8;
  localparam int LEN_LIMIT        = (MAX_ACCESS_BYTES < STEP_RESULTS) ?
                                    MAX_ACCESS_BYTES : STEP_RESULTS;

  localparam int ADDR_W = 64;
  localparam int LEN_W  = 4;
  localparam int SLOT_W = 4;
  localparam int IDX_W  = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  localparam logic OP_MAP      = 1'b0;
  localparam logic OP_DECODE   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    TGT_NONE   = 2'd0,
    TGT_RAM    = 2'd1,
    TGT_DEVICE = 2'd2
  } target_e;

  typedef enum logic {
    TOK_MAP    = 1'b0,
    TOK_LOOKUP = 1'b1
  } tok_kind_e;

  // Token that walks down the row of region cells.
  typedef struct packed {
    logic                valid;
    tok_kind_e           kind;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   size;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   offset;
    logic                last;
  } mrad_tok_t;

  // One finished result.
  typedef struct packed {
    logic                valid;
    logic                status;
    target_e             target;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   offset;
    logic                last;
  } mrad_res_t;

  // Low bits of a slot number as reported in the slot field.
  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mrad_ifs.sv
// Valid/ready channel interfaces of the MMIO region address decoder.
// Depends on mrad_pkg.
`default_nettype none

interface mrad_in_if;
  import mrad_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [ADDR_W-1:0]       address;
  logic [ADDR_W-1:0]       region_size;
  logic [LEN_W-1:0]        access_length;

  modport source (output valid, op, address, region_size, access_length, input ready);
  modport sink   (input valid, op, address, region_size, access_length, output ready);
endinterface

interface mrad_out_if;
  import mrad_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic [1:0]              target;
  logic [SLOT_W-1:0]       slot;
  logic [ADDR_W-1:0]       offset;
  logic                    last;

  modport source (output valid, status, target, slot, offset, last, input ready);
  modport sink   (input valid, status, target, slot, offset, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mrad_cell.sv
// One region cell: holds one slot of the region table and processes the
// token handed on by its neighbor. Depends on mrad_pkg.
`default_nettype none

module mrad_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [mrad_pkg::IDX_W-1:0]   cell_idx_i,
  input  mrad_pkg::mrad_tok_t          tok_i,
  output mrad_pkg::mrad_tok_t          tok_o
);
  import mrad_pkg::*;

  logic                used_q;
  logic [ADDR_W-1:0]   base_q;
  logic [ADDR_W-1:0]   len_q;
  mrad_tok_t           tok_q, tok_d;
  logic [ADDR_W:0]     diff;
  logic                covers;
  logic                claim;

  // Borrow out of the subtraction means the address lies below the base.
  assign diff   = {1'b0, tok_i.addr} - {1'b0, base_q};
  assign covers = used_q && !diff[ADDR_W] && (diff[ADDR_W-1:0] < len_q);
  assign claim  = tok_i.valid && (tok_i.kind == TOK_MAP) && !tok_i.hit && !used_q;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && (tok_i.kind == TOK_LOOKUP) && !tok_i.hit && covers) begin
      tok_d.hit    = 1'b1;
      tok_d.slot   = slot_field(cell_idx_i);
      tok_d.offset = diff[ADDR_W-1:0];
    end
    if (claim) begin
      tok_d.hit = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      used_q <= 1'b0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      if (claim) begin
        used_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && claim) begin
      base_q <= tok_i.addr;
      len_q  <= tok_i.size;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// File: rtl/core/mrad_issue.sv
// Input sequencer: takes one item, settles RAM and special cases, and feeds a map token
// or one lookup token per byte into the cell row. Depends on mrad_pkg, mrad_ifs.
`default_nettype none

module mrad_issue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mrad_in_if.sink                     in_i,
  input  logic [mrad_pkg::ADDR_W-1:0] ram_bytes_i,
  input  logic                        chain_busy_i,
  input  logic                        adv_i,
  output mrad_pkg::mrad_tok_t         head_o,
  output mrad_pkg::mrad_res_t         fix_o,
  output logic                        start_o
);
  import mrad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_ISSUE = 3'b100
  } issue_state_e;

  issue_state_e        state_q, state_d;
  logic                op_q;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [ADDR_W-1:0]   size_q;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W-1:0]    cnt_q, cnt_d;
  logic                accept;
  logic                len_over;
  logic                in_ram;
  logic                final_byte;

  assign in_i.ready = (state_q == ST_IDLE) && !chain_busy_i;
  assign accept     = in_i.valid && in_i.ready;
  assign start_o    = accept;

  assign len_over   = int'(len_q) > LEN_LIMIT;
  assign in_ram     = (addr_q < ram_bytes_i) &&
                      ({{(ADDR_W-LEN_W){1'b0}}, len_q} <= (ram_bytes_i - addr_q));
  assign final_byte = (cnt_q + LEN_W'(1)) == len_q;

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    head_o  = '0;
    fix_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CHECK;
          addr_d  = in_i.address;
        end
      end
      ST_CHECK: begin
        fix_o.last = 1'b1;
        if (op_q == OP_MAP) begin
          if (size_q == '0) begin
            fix_o.valid  = 1'b1;
            fix_o.status = STATUS_FAIL;
          end else begin
            head_o.valid = 1'b1;
            head_o.kind  = TOK_MAP;
            head_o.addr  = addr_q;
            head_o.size  = size_q;
            head_o.last  = 1'b1;
          end
          if (adv_i) begin
            state_d = ST_IDLE;
          end
        end else if (len_q == '0) begin
          fix_o.valid = 1'b1;
          if (adv_i) begin
            state_d = ST_IDLE;
          end
        end else if (len_over) begin
          fix_o.valid  = 1'b1;
          fix_o.status = STATUS_FAIL;
          if (adv_i) begin
            state_d = ST_IDLE;
          end
        end else if (in_ram) begin
          fix_o.valid  = 1'b1;
          fix_o.target = TGT_RAM;
          fix_o.offset = addr_q;
          if (adv_i) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_ISSUE;
          cnt_d   = '0;
        end
      end
      ST_ISSUE: begin
        head_o.valid = 1'b1;
        head_o.kind  = TOK_LOOKUP;
        head_o.addr  = addr_q;
        head_o.last  = final_byte;
        if (adv_i) begin
          addr_d = addr_q + ADDR_W'(1);
          cnt_d  = cnt_q + LEN_W'(1);
          if (final_byte) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cnt_q  <= cnt_d;
    if (accept) begin
      op_q   <= in_i.op;
      size_q <= in_i.region_size;
      len_q  <= in_i.access_length;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mrad_emit.sv
// Output stage: turns tokens leaving the cell row or settled results into
// registered result transfers, and drops bytes after an unmapped one.
// Depends on mrad_pkg, mrad_ifs.
`default_nettype none

module mrad_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  mrad_pkg::mrad_tok_t  tok_i,
  input  mrad_pkg::mrad_res_t  fix_i,
  mrad_out_if.source           out_o,
  output logic                 adv_o
);
  import mrad_pkg::*;

  mrad_res_t out_q, res_d;
  logic      drop_q;
  logic      drop_set;

  assign adv_o = !out_q.valid || out_o.ready;

  always_comb begin
    res_d    = '0;
    drop_set = 1'b0;
    if (tok_i.valid && !drop_q) begin
      res_d.valid = 1'b1;
      res_d.last  = 1'b1;
      if (tok_i.kind == TOK_MAP) begin
        res_d.status = tok_i.hit ? STATUS_OK : STATUS_FAIL;
      end else if (tok_i.hit) begin
        res_d.status = STATUS_OK;
        res_d.target = TGT_DEVICE;
        res_d.slot   = tok_i.slot;
        res_d.offset = tok_i.offset;
        res_d.last   = tok_i.last;
      end else begin
        res_d.status = STATUS_FAIL;
        drop_set     = 1'b1;
      end
    end else if (fix_i.valid) begin
      res_d = fix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      if (start_i) begin
        drop_q <= 1'b0;
      end else if (adv_o && drop_set) begin
        drop_q <= 1'b1;
      end
      if (adv_o) begin
        out_q <= res_d;
      end
    end
  end

  assign out_o.valid  = out_q.valid;
  assign out_o.status = out_q.status;
  assign out_o.target = out_q.target;
  assign out_o.slot   = out_q.slot;
  assign out_o.offset = out_q.offset;
  assign out_o.last   = out_q.last;

endmodule

`default_nettype wire

// File: rtl/core/mmio_region_address_decoder_unit.sv
// Top level of the MMIO region address decoder: sequencer, row of region
// cells and output stage. Depends on mrad_pkg, mrad_ifs, mrad_issue, mrad_cell, mrad_emit.
//
//   Channel  | Direction | Handshake       | Carries
//   in_i     | in        | valid/ready     | op, address, region_size, access_length
//   out_o    | out       | valid/ready     | status, target, slot, offset, last
//   cfg      | in        | cfg_we_i only   | RAM size in cfg_wdata_i
//
// One item is handled at a time. Results that need no table walk (bad size,
// zero or overlong length, RAM span) are set up in the sequencer's check state and
// registered by the output stage. A map, and each byte of a device access, walks the
// row of REGION_COUNT cells one cell per cycle while the output is not stalled; the
// bytes enter one after another. The next input is taken once the cell row has drained,
// even while the last result still waits. A stalled output freezes the whole row.
// Reset clears the table and the RAM size.
`default_nettype none

module mmio_region_address_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mrad_in_if.sink                     in_i,
  mrad_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [mrad_pkg::ADDR_W-1:0] cfg_wdata_i
);
  import mrad_pkg::*;

  logic [ADDR_W-1:0] ram_bytes_q;
  mrad_tok_t         chain [REGION_COUNT+1];
  mrad_res_t         fix;
  logic              adv;
  logic              start;
  logic              chain_busy;

  // RAM size register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_bytes_q <= '0;
    end else if (cfg_we_i) begin
      ram_bytes_q <= cfg_wdata_i;
    end
  end

  mrad_issue u_issue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .ram_bytes_i  (ram_bytes_q),
    .chain_busy_i (chain_busy),
    .adv_i        (adv),
    .head_o       (chain[0]),
    .fix_o        (fix),
    .start_o      (start)
  );

  // Slot 0 sits at the head, so the first match on the way down is the
  // lowest matching slot and the first free cell is the lowest free slot.
  for (genvar i = 0; i < REGION_COUNT; i++) begin : g_cell
    mrad_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (IDX_W'(i)),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1])
    );
  end

  // Any token still inside the row keeps the next item out.
  always_comb begin
    chain_busy = 1'b0;
    for (int i = 1; i <= REGION_COUNT; i++) begin
      chain_busy = chain_busy | chain[i].valid;
    end
  end

  mrad_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .tok_i   (chain[REGION_COUNT]),
    .fix_i   (fix),
    .out_o   (out_o),
    .adv_o   (adv)
  );

  // A settled result is only produced while the row is empty.
  a_fix_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fix.valid && chain[REGION_COUNT].valid))
    else $error("settled result collides with a token leaving the cell row");

  // Taking an item moves the sequencer out of its idle state.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken twice in a row");

  // A failure never names a target and is always final.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == STATUS_FAIL) |-> (out_o.target == TGT_NONE && out_o.last))
    else $error("failure result carries a target or is not final");

  // A RAM span is always the only result of its item.
  a_ram_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.target == TGT_RAM) |-> out_o.last)
    else $error("RAM span result not marked final");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for mmio_region_address_decoder_unit: directed rows, then random
// traffic, every result compared with an in-bench model of the region table.
// Depends on mrad_pkg, mrad_ifs and the decoder RTL.

module testbench;
  import mrad_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int PHASE_ITEMS  = 88;   // five random phases, one RAM size setting each
  localparam int PHASE_COUNT  = 5;
  localparam int PAUSE_AT     = 300;  // random item at which the sender waits for a full drain
  localparam int HOLD_AT      = 150;  // items sent before the receiver's long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000; // cycles without any transfer before the run is abandoned
  // A map walks the whole cell row; the bytes of a decode enter one after another on top of that.
  localparam int DRAIN_CYCLES = REGION_COUNT + MAX_ACCESS_BYTES + 8;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_size;
    logic [LEN_W-1:0]  access_length;
  } access_t;

  typedef struct packed {
    logic              status;
    target_e           target;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] offset;
    logic              last;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_RAM} row_kind_e;

  // One row of the directed table: either an input item or a RAM size write.
  // Rows whose outcome is obvious carry their expected result typed in.
  typedef struct packed {
    row_kind_e         kind;
    access_t           item;
    logic [ADDR_W-1:0] ram_value;
    logic              has_result;
    result_t           result;
  } row_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  mrad_in_if  in_if ();
  mrad_out_if out_if ();

  mmio_region_address_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the decoder state: RAM size and the region table.
  logic [ADDR_W-1:0] ram_bytes;
  logic              slot_taken [REGION_COUNT];
  logic [ADDR_W-1:0] slot_base  [REGION_COUNT];
  logic [ADDR_W-1:0] slot_span  [REGION_COUNT];
  int                slots_in_use;

  // Results still owed by the decoder, oldest first.
  result_t awaited [$];

  int fail_count   = 0;
  int items_sent   = 0;
  int maps_sent    = 0;
  int results_seen = 0;
  int burst_left   = 1;
  int idle_cycles  = 0;

  int       hold_left = 0;
  logic     hold_done = 1'b0;
  rx_mode_e rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       rx_tick   = 0;

  row_t directed [24];

  // Lowest used slot whose region covers the byte address. A region only covers
  // addresses at or above its base, so a region that runs past the top of the
  // address space does not reach around to address zero.
  function automatic int find_slot(input logic [ADDR_W-1:0] pa, output logic [ADDR_W-1:0] off);
    off = '0;
    for (int s = 0; s < REGION_COUNT; s++) begin
      if (slot_taken[s] && pa >= slot_base[s] && pa - slot_base[s] < slot_span[s]) begin
        off = pa - slot_base[s];
        return s;
      end
    end
    return -1;
  endfunction

  // Works out the results of one accepted item, updates the shadow table and
  // appends the results to the awaited queue.
  function automatic void predict_results(input access_t a);
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] pa;
    logic [ADDR_W-1:0] off;
    result_t           r;
    int                s;
    int                i;
    r = '{status: STATUS_OK, target: TGT_NONE, slot: '0, offset: '0, last: 1'b1};
    if (a.op == OP_MAP) begin
      // A zero size or a full table is refused; otherwise the lowest free slot is claimed.
      r.status = STATUS_FAIL;
      if (a.region_size != '0) begin
        for (s = 0; s < REGION_COUNT; s++) begin
          if (!slot_taken[s]) begin
            slot_taken[s] = 1'b1;
            slot_base[s]  = a.address;
            slot_span[s]  = a.region_size;
            slots_in_use++;
            r.status = STATUS_OK;
            break;
          end
        end
      end
      awaited.push_back(r);
      return;
    end
    len = ADDR_W'(a.access_length);
    if (len == '0) begin
      awaited.push_back(r);
      return;
    end
    if (len > LEN_LIMIT) begin
      r.status = STATUS_FAIL;
      awaited.push_back(r);
      return;
    end
    // The whole span inside RAM gives a single result.
    if (a.address < ram_bytes && len <= ram_bytes - a.address) begin
      r.target = TGT_RAM;
      r.offset = a.address;
      awaited.push_back(r);
      return;
    end
    // Byte by byte through the table; the first uncovered byte ends the access.
    for (i = 0; i < len; i++) begin
      pa = a.address + ADDR_W'(i);
      s  = find_slot(pa, off);
      if (s < 0) begin
        r = '{status: STATUS_FAIL, target: TGT_NONE, slot: '0, offset: '0, last: 1'b1};
        awaited.push_back(r);
        return;
      end
      r.status = STATUS_OK;
      r.target = TGT_DEVICE;
      r.slot   = SLOT_W'(s);
      r.offset = off;
      r.last   = (i == len - 1);
      awaited.push_back(r);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $error("testbench: %s expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic row_t decode_row(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    row_t r;
    r = '0;
    r.kind               = ROW_ITEM;
    r.item.op            = OP_DECODE;
    r.item.address       = addr;
    r.item.access_length = len;
    return r;
  endfunction

  function automatic row_t map_row(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size);
    row_t r;
    r = '0;
    r.kind             = ROW_ITEM;
    r.item.op          = OP_MAP;
    r.item.address     = base;
    r.item.region_size = size;
    return r;
  endfunction

  function automatic row_t ram_row(input logic [ADDR_W-1:0] value);
    row_t r;
    r = '0;
    r.kind      = ROW_RAM;
    r.ram_value = value;
    return r;
  endfunction

  function automatic row_t with_result(input row_t r, input logic status, input target_e tgt,
                                       input logic [ADDR_W-1:0] off);
    r.has_result = 1'b1;
    r.result     = '{status: status, target: tgt, slot: '0, offset: off, last: 1'b1};
    return r;
  endfunction

  // Random item. Maps are rare so the table fills gradually over the run; decode
  // addresses cluster around region bases, the RAM boundary and the top of memory.
  function automatic access_t random_access();
    access_t a;
    int      pick;
    int      s;
    a.op            = OP_DECODE;
    a.region_size   = {$urandom, $urandom};
    a.access_length = LEN_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      a.op = OP_MAP;
      case ($urandom_range(0, 3))
        0, 1:    a.address = ADDR_W'($urandom_range(0, 'h4000));
        2:       a.address = {$urandom, $urandom};
        default: a.address = ADDR_TOP - ADDR_W'($urandom_range(0, 32));
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 7)       a.region_size = ADDR_W'($urandom_range(1, 64));
      else if (pick == 7) a.region_size = '0;
      else if (pick == 8) a.region_size = {$urandom, $urandom};
      else                a.region_size = ADDR_TOP - ADDR_W'($urandom_range(0, 15));
      return a;
    end
    pick = $urandom_range(0, 99);
    if (pick < 80)      a.access_length = LEN_W'($urandom_range(1, LEN_LIMIT));
    else if (pick < 88) a.access_length = '0;
    else                a.access_length = LEN_W'($urandom_range(LEN_LIMIT + 1, 15));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // Slot 0 is always in use once the directed rows are done.
      s = $urandom_range(0, REGION_COUNT - 1);
      while (!slot_taken[s]) s = (s + 1) % REGION_COUNT;
      a.address = slot_base[s] + ADDR_W'($urandom_range(0, 24)) - ADDR_W'(4);
    end else if (pick < 60) begin
      a.address = ram_bytes - ADDR_W'($urandom_range(0, 12));
    end else if (pick < 75) begin
      a.address = ADDR_TOP - ADDR_W'($urandom_range(0, 12));
    end else if (pick < 85) begin
      a.address = ADDR_W'($urandom_range(0, 'h40));
    end else begin
      a.address = {$urandom, $urandom};
    end
    return a;
  endfunction

  // Sender pacing: bursts of random length with random gaps. Pacing drops valid only
  // when a gap starts, so back-to-back items never toggle it within one step.
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 9) == 0) ? 48 : $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Offers one item and holds it until the transfer. The prediction is made at
  // the transfer edge; a typed-in result replaces the predicted one.
  task automatic offer(input access_t a, input logic typed, input result_t want);
    in_if.valid         <= 1'b1;
    in_if.op            <= a.op;
    in_if.address       <= a.address;
    in_if.region_size   <= a.region_size;
    in_if.access_length <= a.access_length;
    do @(posedge clk_i); while (!in_if.ready);
    predict_results(a);
    if (typed) begin
      void'(awaited.pop_back());
      awaited.push_back(want);
    end
    items_sent++;
    if (a.op == OP_MAP) maps_sent++;
    pace();
  endtask

  // Stops offering, waits for every owed result, then lets the cell row drain.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ram(input logic [ADDR_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    ram_bytes = value;
  endtask

  // Receiver: switches between always ready, random stalls and a periodic
  // pattern, and once holds ready low for a long stretch so the decoder backs up.
  always @(posedge clk_i) begin
    rx_tick++;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_RANDOM: out_if.ready <= ($urandom_range(0, 99) < 60);
        default:   out_if.ready <= (rx_tick % 5) != 4;
      endcase
    end
  end

  // Result checker: every output transfer is matched against the oldest owed result.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        $error("testbench: result with nothing expected (status %0d target %0d offset %0h)",
               out_if.status, out_if.target, out_if.offset);
        fail_count++;
      end else begin
        want = awaited.pop_front();
        compare_field("status", ADDR_W'(want.status), ADDR_W'(out_if.status));
        compare_field("target", ADDR_W'(want.target), ADDR_W'(out_if.target));
        compare_field("slot",   ADDR_W'(want.slot),   ADDR_W'(out_if.slot));
        compare_field("offset", want.offset,          out_if.offset);
        compare_field("last",   ADDR_W'(want.last),   ADDR_W'(out_if.last));
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either channel means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: no transfer for %0d cycles, %0d results still owed",
                 idle_cycles, awaited.size());
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    access_t a;
    row_t    row;
    result_t no_result;
    int      phase;
    int      n;

    in_if.valid         = 1'b0;
    in_if.op            = OP_MAP;
    in_if.address       = '0;
    in_if.region_size   = '0;
    in_if.access_length = '0;
    out_if.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    rst_ni              = 1'b0;
    no_result           = '0;
    ram_bytes           = '0;
    slots_in_use        = 0;
    for (int s = 0; s < REGION_COUNT; s++) begin
      slot_taken[s] = 1'b0;
      slot_base[s]  = '0;
      slot_span[s]  = '0;
    end

    // Directed rows. The first block runs with the RAM size at its reset value of zero.
    directed = '{
      with_result(decode_row('0, 0), STATUS_OK, TGT_NONE, '0),
      with_result(decode_row(64'h40, 9), STATUS_FAIL, TGT_NONE, '0),
      with_result(decode_row(ADDR_TOP, 15), STATUS_FAIL, TGT_NONE, '0),
      with_result(decode_row('0, 1), STATUS_FAIL, TGT_NONE, '0),
      with_result(map_row(64'h1000, '0), STATUS_FAIL, TGT_NONE, '0),
      with_result(map_row(64'h1000, 64'h4), STATUS_OK, TGT_NONE, '0),
      decode_row(64'h0FFE, 4),
      decode_row(64'h1000, 8),
      with_result(map_row(64'hFFFF_FFFF_FFFF_FFFC, 64'h8), STATUS_OK, TGT_NONE, '0),
      decode_row(64'hFFFF_FFFF_FFFF_FFFE, 8),
      with_result(map_row(64'h1002, ADDR_TOP), STATUS_OK, TGT_NONE, '0),
      decode_row(64'h1000, 8),
      decode_row(ADDR_TOP, 8),
      // RAM covering all but the top byte of the address space.
      ram_row(ADDR_TOP),
      with_result(decode_row('0, 8), STATUS_OK, TGT_RAM, '0),
      decode_row(ADDR_TOP, 1),
      with_result(decode_row(64'hFFFF_FFFF_FFFF_FFF7, 8), STATUS_OK, TGT_RAM,
                  64'hFFFF_FFFF_FFFF_FFF7),
      decode_row(64'hFFFF_FFFF_FFFF_FFF8, 8),
      with_result(decode_row(ADDR_TOP, 12), STATUS_FAIL, TGT_NONE, '0),
      // Small RAM: accesses straddling its end fall through to the table.
      ram_row(64'h2000),
      with_result(decode_row(64'h1FF8, 8), STATUS_OK, TGT_RAM, 64'h1FF8),
      decode_row(64'h1FF9, 8),
      decode_row(64'h2000, 1),
      with_result(map_row(ADDR_TOP, ADDR_TOP), STATUS_OK, TGT_NONE, '0)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_RAM) write_ram(directed[k].ram_value);
      else offer(directed[k].item, directed[k].has_result, directed[k].result);
    end

    // Random traffic in phases, each under its own RAM size.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       write_ram(64'h1800);
        1:       write_ram('0);
        2:       write_ram({$urandom, $urandom});
        3:       write_ram(ADDR_TOP);
        default: write_ram(64'h1_0000);
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase * PHASE_ITEMS + n == PAUSE_AT) settle();
        offer(random_access(), 1'b0, no_result);
      end
    end

    // Fill whatever is left of the table, then show that a full table refuses a map.
    while (slots_in_use < REGION_COUNT) begin
      a             = random_access();
      a.op          = OP_MAP;
      a.region_size = ADDR_W'($urandom_range(1, 64));
      offer(a, 1'b0, no_result);
    end
    row = with_result(map_row(64'h2000, 64'h10), STATUS_FAIL, TGT_NONE, '0);
    offer(row.item, 1'b1, row.result);

    settle();
    $display("testbench: %0d items sent (%0d maps, %0d decodes), %0d results checked",
             items_sent, maps_sent, items_sent - maps_sent, results_seen);
    $display("testbench: RAM size swept from zero to all ones, region table filled to %0d slots",
             slots_in_use);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
